@@ hdl/prw_pkg.sv @@
`timescale 1ns / 1ps

package prw_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int COUNT_W       = IDX_W + 1;
    localparam int WEIGHT_BITS   = 16;
    localparam int BETA_BITS     = WEIGHT_BITS + 2;
    localparam int FRAC_BITS     = 16;
    localparam int PROD_W        = FRAC_BITS + WEIGHT_BITS;
    // Twice the maximum, then a shift by the fraction width, leaves FRAC_BITS - 1.
    localparam int SCALE_SHIFT   = FRAC_BITS - 1;
    localparam int SCALED_W      = PROD_W - SCALE_SHIFT;
    localparam int WALK_TURNS    = 4;
    localparam int STEP_W        = COUNT_W + $clog2(WALK_TURNS);
    localparam int MOD_SHIFT_W   = $clog2(IDX_W);

    // Input tdata layout, lowest bit first.
    localparam int TD_WIDX_LO    = 0;
    localparam int TD_WVAL_LO    = TD_WIDX_LO + IDX_W;
    localparam int TD_FRAC_LO    = TD_WVAL_LO + WEIGHT_BITS;
    localparam int TD_RESTART    = TD_FRAC_LO + FRAC_BITS;
    localparam int TD_START_LO   = TD_RESTART + 1;
    localparam int TD_USED       = TD_START_LO + IDX_W;
    localparam int S_TDATA_W     = ((TD_USED + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((IDX_W + 7) / 8) * 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } prw_op_t;

endpackage

@@ hdl/particle_resampling_wheel_top.sv @@
`timescale 1ns / 1ps

// Resampling-wheel selector. A load beat writes one weight into the on-chip
// weight store and keeps a running maximum (index 0 restarts it). A draw beat
// returns one chosen particle index after walking n wheel steps (n at most
// 4 x particle count), and the input takes its next beat once that result is
// moved to the output register: the walk reads one weight store entry per
// cycle from a memory with a registered read port. When the starting wheel
// position (kept, or given on restart) is not below the particle count, a
// shift-subtract reduction of that position into range comes first.
// A finished result waits in the output register; load beats and the next
// draw are still accepted meanwhile, but that draw keeps its own result, and
// holds off the input, until the previous result is taken.
// Only entries that have been loaded may be walked over.
module particle_resampling_wheel_top
    import prw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [COUNT_W-1:0]   cfg_wr_data,   // particle_count
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [9:0] weight_index, [25:10] weight_value, [41:26] random_fraction,
    // [42] restart, [52:43] start_index, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,  // [0] opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [9:0] chosen_index, rest zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_BETA,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [COUNT_W-1:0]       count_cfg_reg;
    logic [WEIGHT_BITS-1:0]   max_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic [BETA_BITS-1:0]     beta_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [MOD_SHIFT_W-1:0]   shift_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_data_reg;

    logic [WEIGHT_BITS-1:0]   weight_mem [MAX_PARTICLES];
    logic [WEIGHT_BITS-1:0]   rd_data_reg;
    logic [IDX_W-1:0]         rd_addr;

    logic [IDX_W-1:0]         in_widx;
    logic [WEIGHT_BITS-1:0]   in_wval;
    logic [FRAC_BITS-1:0]     in_frac;
    logic                     in_restart;
    logic [IDX_W-1:0]         in_start;
    logic                     in_fire;
    logic                     load_fire;
    logic                     draw_fire;

    logic [COUNT_W-1:0]       live_count;
    logic [STEP_W-1:0]        walk_limit;
    logic [IDX_W-1:0]         start_pos;
    logic [IDX_W:0]           pos_inc;
    logic [IDX_W-1:0]         pos_wrap;
    logic [COUNT_W+IDX_W-1:0] mod_divisor;
    logic                     mod_sub;
    logic [SCALED_W-1:0]      scaled;
    logic [BETA_BITS:0]       beta_sum;
    logic [BETA_BITS-1:0]     beta_sat;
    logic                     out_free;

    assign in_widx    = s_axis_tdata[TD_WIDX_LO +: IDX_W];
    assign in_wval    = s_axis_tdata[TD_WVAL_LO +: WEIGHT_BITS];
    assign in_frac    = s_axis_tdata[TD_FRAC_LO +: FRAC_BITS];
    assign in_restart = s_axis_tdata[TD_RESTART];
    assign in_start   = s_axis_tdata[TD_START_LO +: IDX_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_fire     = in_fire && (s_axis_tuser == OP_LOAD);
    assign draw_fire     = in_fire && (s_axis_tuser == OP_DRAW);

    // A count of zero behaves as one; anything above the store depth is clamped.
    always_comb
    begin
        if (count_cfg_reg == '0)
            live_count = COUNT_W'(1);
        else if (count_cfg_reg > COUNT_W'(MAX_PARTICLES))
            live_count = COUNT_W'(MAX_PARTICLES);
        else
            live_count = count_cfg_reg;
    end

    assign walk_limit = STEP_W'(live_count) * STEP_W'(WALK_TURNS);
    assign start_pos  = in_restart ? in_start : pos_reg;

    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign pos_wrap = (pos_inc >= live_count) ? '0 : pos_inc[IDX_W-1:0];

    assign mod_divisor = {{IDX_W{1'b0}}, live_count} << shift_reg;
    assign mod_sub     = {{COUNT_W{1'b0}}, pos_reg} >= mod_divisor;

    assign scaled   = prod_reg[PROD_W-1:SCALE_SHIFT];
    assign beta_sum = {1'b0, beta_reg} + (BETA_BITS+1)'(scaled);
    assign beta_sat = beta_sum[BETA_BITS] ? {BETA_BITS{1'b1}} : beta_sum[BETA_BITS-1:0];

    assign out_free = !out_valid_reg || m_axis_tready;

    // While walking, the read is already aimed at the next wheel position so
    // that a step can follow in every cycle.
    assign rd_addr = (state_reg == ST_WALK) ? pos_wrap : pos_reg;

    always_ff @(posedge clk)
    begin
        if (load_fire)
            weight_mem[in_widx] <= in_wval;
        rd_data_reg <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= COUNT_W'(MAX_PARTICLES);
        end
        else if (cfg_wr_en)
        begin
            count_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            pos_reg       <= '0;
            beta_reg      <= '0;
            prod_reg      <= '0;
            step_reg      <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // In ST_DONE the output register is either refilled below or still
            // held, so the beat is only retired here in the other states.
            if (m_axis_tready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_fire)
                    begin
                        if (in_widx == '0)
                            max_reg <= in_wval;
                        else if (in_wval > max_reg)
                            max_reg <= in_wval;
                    end
                    else if (draw_fire)
                    begin
                        prod_reg  <= PROD_W'(in_frac) * PROD_W'(max_reg);
                        pos_reg   <= start_pos;
                        step_reg  <= '0;
                        shift_reg <= MOD_SHIFT_W'(IDX_W - 1);
                        if (in_restart)
                            beta_reg <= '0;
                        if ({1'b0, start_pos} >= live_count)
                            state_reg <= ST_MOD;
                        else
                            state_reg <= ST_BETA;
                    end
                end

                ST_MOD:
                begin
                    if (mod_sub)
                        pos_reg <= pos_reg - mod_divisor[IDX_W-1:0];
                    if (shift_reg == '0)
                        state_reg <= ST_BETA;
                    else
                        shift_reg <= shift_reg - 1'b1;
                end

                ST_BETA:
                begin
                    beta_reg  <= beta_sat;
                    state_reg <= ST_WALK;
                end

                ST_WALK:
                begin
                    if (step_reg == walk_limit)
                        state_reg <= ST_DONE;
                    else if (beta_reg <= BETA_BITS'(rd_data_reg))
                        state_reg <= ST_DONE;
                    else
                    begin
                        beta_reg <= beta_reg - BETA_BITS'(rd_data_reg);
                        pos_reg  <= pos_wrap;
                        step_reg <= step_reg + 1'b1;
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= pos_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_data_reg);

endmodule
